[sv/z_score_standardizer_core_defines.svh]
// assertion macros for the z-score standardizer
`ifndef Z_SCORE_STANDARDIZER_CORE_DEFINES_SVH
`define Z_SCORE_STANDARDIZER_CORE_DEFINES_SVH

// a condition that must hold at every clock edge outside reset
`define ZS_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// an antecedent that forces a consequent in the following cycle
`define ZS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

[sv/zss_pkg.sv]
// ---------------------------------------------------------------------------
// zss_pkg
// shared constants and types of the z-score standardizer
// ---------------------------------------------------------------------------
`default_nettype none
package zss_pkg;
    localparam int SAMPLE_W = 16;
    localparam int Z_W      = 24;
    localparam int STAT_W   = 2;
    localparam int DIFF_W   = 24;   // |n*x - S| < 2^23
    localparam int DSUM_W   = 53;   // 64 * 2^46
    localparam int LHS_W    = 101;  // (2m-1)^2 * dsum < 2^48 * 2^53
    localparam int MAG_W    = 24;

    localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
    localparam logic [STAT_W-1:0] ST_SHORT    = 2'd1;
    localparam logic [STAT_W-1:0] ST_FLAT     = 2'd2;
    localparam logic [STAT_W-1:0] ST_OVERFLOW = 2'd3;

    localparam logic [MAG_W-1:0] MAG_CAP = 24'd8388608;
    localparam logic [Z_W-1:0]   Z_MAX   = 24'd8388607;

    typedef struct packed {
        logic signed [Z_W-1:0] zscore;
        logic [STAT_W-1:0]     status;
        logic                  last_result;
    } result_t;
endpackage
`default_nettype wire

[sv/zss_magnitude.sv]
// ---------------------------------------------------------------------------
// zss_magnitude
// bit-serial search for the rounded z magnitude: largest m with
// 4*d^2*(n-1)*2^32 >= (2m-1)^2 * dsum, capped at 2^23
// ---------------------------------------------------------------------------
`default_nettype none
module zss_magnitude
(
    input  wire                          clk,
    input  wire                          rst_n,
    input  wire                          start,
    input  wire [zss_pkg::DIFF_W-1:0]    abs_diff,
    input  wire [6:0]                    nm1,
    input  wire [zss_pkg::DSUM_W-1:0]    dsum,
    output logic                         done,
    output logic [zss_pkg::MAG_W-1:0]    mag
);
    import zss_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_SQ   = 3'd1;
    localparam logic [2:0] S_LHS  = 3'd2;
    localparam logic [2:0] S_TRY  = 3'd3;
    localparam logic [2:0] S_CMP  = 3'd4;
    localparam logic [2:0] S_MUL  = 3'd5;
    localparam logic [2:0] S_MUL2 = 3'd6;
    localparam logic [2:0] S_MUL3 = 3'd7;

    logic [2:0]            state_reg, state_next;
    logic [4:0]            bit_reg, bit_next;
    logic [MAG_W-1:0]      m_reg, m_next;
    logic [47:0]           sq_reg, sq_next;
    logic [LHS_W-1:0]      lhs_reg, lhs_next;
    logic [47:0]           t2_reg, t2_next;
    logic [LHS_W-1:0]      rhs_reg, rhs_next;
    logic [MAG_W-1:0]      cand;
    logic [MAG_W:0]        tval;
    logic                  done_reg, done_next;

    // candidate adds the current bit; the cap bit is tested first
    always_comb
    begin
        cand = m_reg | (MAG_W'(1) << bit_reg);
        tval = {cand, 1'b0} - 25'd1;
    end

    always_comb
    begin
        state_next = state_reg;
        bit_next   = bit_reg;
        m_next     = m_reg;
        sq_next    = sq_reg;
        lhs_next   = lhs_reg;
        t2_next    = t2_reg;
        rhs_next   = rhs_reg;
        done_next  = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    sq_next    = 48'(abs_diff) * 48'(abs_diff);
                    state_next = S_SQ;
                end
            end
            S_SQ:
            begin
                lhs_next   = (LHS_W'(sq_reg) * LHS_W'(nm1)) << 34;
                m_next     = '0;
                bit_next   = 5'd23;
                state_next = S_LHS;
            end
            S_LHS:
            begin
                t2_next    = 48'(tval) * 48'(tval);
                state_next = S_MUL;
            end
            S_MUL:
            begin
                // split the 48x53 product into four partial products
                rhs_next   = LHS_W'(t2_reg[23:0]) * LHS_W'(dsum[26:0]);
                state_next = S_MUL2;
            end
            S_MUL2:
            begin
                rhs_next   = rhs_reg
                             + ((LHS_W'(t2_reg[47:24]) * LHS_W'(dsum[26:0])) << 24);
                state_next = S_MUL3;
            end
            S_MUL3:
            begin
                rhs_next   = rhs_reg
                             + ((LHS_W'(t2_reg[23:0]) * LHS_W'(dsum[DSUM_W-1:27])) << 27);
                state_next = S_TRY;
            end
            S_TRY:
            begin
                rhs_next   = rhs_reg
                             + ((LHS_W'(t2_reg[47:24]) * LHS_W'(dsum[DSUM_W-1:27])) << 51);
                state_next = S_CMP;
            end
            S_CMP:
            begin
                if (lhs_reg >= rhs_reg)
                    m_next = cand;
                if (bit_reg == 5'd23 && lhs_reg >= rhs_reg)
                begin
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
                else if (bit_reg == 5'd0)
                begin
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    bit_next   = bit_reg - 5'd1;
                    state_next = S_LHS;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        bit_reg <= bit_next;
        m_reg   <= m_next;
        sq_reg  <= sq_next;
        lhs_reg <= lhs_next;
        t2_reg  <= t2_next;
        rhs_reg <= rhs_next;
    end

    assign done = done_reg;
    assign mag  = m_reg;
endmodule
`default_nettype wire

[sv/z_score_standardizer_core.sv]
// ---------------------------------------------------------------------------
// z_score_standardizer_core
// run-based z-score standardization of signed 16-bit samples
// ---------------------------------------------------------------------------
// usage:
//   s_axis carries one sample per request (tdata) with tlast marking the end
//   of a run. samples load at one per cycle into a 64-entry sample memory
//   while the running sum is kept. on the marked sample the core stops taking
//   requests, sweeps the memory once for the squared deviation
//   sum, then sweeps again, producing one z-score per stored sample in arrival
//   order on m_axis, the final one with tlast.
//   each result comes from the shared bit-serial magnitude search, which tests
//   one of 24 magnitude bits per pass through its split multiply and stops
//   early when the value saturates. short or flat runs skip the search and
//   give a zero result for each stored sample.
//   results wait in an output register; a stalled m_axis holds the core.
//   reset empties the run; the sample memory needs no clearing.
// ---------------------------------------------------------------------------
`default_nettype none
module z_score_standardizer_core
#(
    parameter int MAX_SAMPLES = 64
)
(
    input  wire          clk,
    input  wire          rst_n,
    input  wire          s_axis_tvalid,
    output logic         s_axis_tready,
    input  wire  [15:0]  s_axis_tdata,   // sample[15:0]
    input  wire          s_axis_tlast,
    output logic         m_axis_tvalid,
    input  wire          m_axis_tready,
    output logic [23:0]  m_axis_tdata,   // zscore[23:0]
    output logic [1:0]   m_axis_tuser,   // status[1:0]
    output logic         m_axis_tlast
);
    import zss_pkg::*;
    `include "z_score_standardizer_core_defines.svh"

    localparam int AW = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;
    localparam int CW = $clog2(MAX_SAMPLES + 1);

    localparam logic [2:0] P_LOAD  = 3'd0;
    localparam logic [2:0] P_SUMSQ = 3'd1;
    localparam logic [2:0] P_RD    = 3'd2;
    localparam logic [2:0] P_MAG   = 3'd3;
    localparam logic [2:0] P_OUT   = 3'd4;
    localparam logic [2:0] P_WAIT  = 3'd5;
    localparam logic [2:0] P_START = 3'd6;

    logic [SAMPLE_W-1:0] mem [MAX_SAMPLES];
    logic [SAMPLE_W-1:0] rd_data_reg;
    logic [AW-1:0]       rd_addr;
    logic                wr_en;

    logic [2:0]          phase_reg, phase_next;
    logic [CW-1:0]       count_reg, count_next;
    logic signed [21:0]  sum_reg, sum_next;
    logic                ovf_reg, ovf_next;
    logic [CW-1:0]       idx_reg, idx_next;
    logic                rd_vld_reg, rd_vld_next;
    logic                acc_vld_reg, acc_vld_next;
    logic [DSUM_W-1:0]   dsum_reg, dsum_next;
    logic [STAT_W-1:0]   stat_reg, stat_next;
    logic                neg_reg, neg_next;
    logic [DIFF_W-1:0]   ad_reg, ad_next;
    logic                mag_start;
    logic                mag_done;
    logic [MAG_W-1:0]    mag;
    result_t             out_reg, out_next;
    logic                ovalid_reg, ovalid_next;

    logic signed [DIFF_W-1:0] diff;
    logic [DIFF_W-1:0]        adiff;
    logic [CW-1:0]            nm1;

    assign s_axis_tready = (phase_reg == P_LOAD);
    assign wr_en = s_axis_tvalid && s_axis_tready && (count_reg < CW'(MAX_SAMPLES));
    assign rd_addr = idx_reg[AW-1:0];
    assign nm1 = count_reg - CW'(1);

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[count_reg[AW-1:0]] <= s_axis_tdata;
        rd_data_reg <= mem[rd_addr];
    end

    always_comb
    begin
        diff  = DIFF_W'($signed({1'b0, count_reg})) * DIFF_W'($signed(rd_data_reg))
                - DIFF_W'(sum_reg);
        adiff = diff[DIFF_W-1] ? DIFF_W'(-diff) : DIFF_W'(diff);
    end

    always_comb
    begin
        phase_next   = phase_reg;
        count_next   = count_reg;
        sum_next     = sum_reg;
        ovf_next     = ovf_reg;
        idx_next     = idx_reg;
        rd_vld_next  = 1'b0;
        acc_vld_next = 1'b0;
        dsum_next    = dsum_reg;
        stat_next    = stat_reg;
        neg_next     = neg_reg;
        ad_next      = ad_reg;
        mag_start    = 1'b0;
        out_next     = out_reg;
        ovalid_next  = ovalid_reg;
        if (ovalid_reg && m_axis_tready)
            ovalid_next = 1'b0;
        case (phase_reg)
            P_LOAD:
            begin
                if (s_axis_tvalid)
                begin
                    if (wr_en)
                    begin
                        count_next = count_reg + CW'(1);
                        sum_next   = sum_reg + 22'($signed(s_axis_tdata));
                    end
                    else
                        ovf_next = 1'b1;
                    if (s_axis_tlast)
                    begin
                        idx_next   = '0;
                        dsum_next  = '0;
                        phase_next = P_SUMSQ;
                    end
                end
            end
            P_SUMSQ:
            begin
                // read, take the deviation, then square and accumulate
                ad_next      = adiff;
                acc_vld_next = rd_vld_reg;
                if (acc_vld_reg)
                    dsum_next = dsum_reg + DSUM_W'(ad_reg) * DSUM_W'(ad_reg);
                if (idx_reg < count_reg)
                begin
                    idx_next    = idx_reg + CW'(1);
                    rd_vld_next = 1'b1;
                end
                else if (!rd_vld_reg && !acc_vld_reg)
                begin
                    if (count_reg < CW'(2))
                        stat_next = ST_SHORT;
                    else if (dsum_reg == '0)
                        stat_next = ST_FLAT;
                    else if (ovf_reg)
                        stat_next = ST_OVERFLOW;
                    else
                        stat_next = ST_OK;
                    idx_next   = '0;
                    phase_next = P_RD;
                end
            end
            P_RD:
            begin
                if (!rd_vld_reg)
                    rd_vld_next = 1'b1;
                else
                begin
                    neg_next = diff[DIFF_W-1];
                    ad_next  = adiff;
                    if (stat_reg == ST_OK || stat_reg == ST_OVERFLOW)
                        phase_next = P_START;
                    else
                        phase_next = P_WAIT;
                end
            end
            P_START:
            begin
                mag_start  = 1'b1;
                phase_next = P_MAG;
            end
            P_MAG:
            begin
                if (mag_done)
                    phase_next = P_OUT;
            end
            P_OUT, P_WAIT:
            begin
                if (!ovalid_next)
                begin
                    if (phase_reg == P_WAIT)
                        out_next.zscore = '0;
                    else if (neg_reg)
                        out_next.zscore = Z_W'(-$signed({1'b0, mag}));
                    else if (mag >= MAG_CAP)
                        out_next.zscore = Z_MAX;
                    else
                        out_next.zscore = Z_W'(mag);
                    out_next.status      = stat_reg;
                    out_next.last_result = (idx_reg + CW'(1) == count_reg);
                    ovalid_next          = 1'b1;
                    if (idx_reg + CW'(1) == count_reg)
                    begin
                        count_next = '0;
                        sum_next   = '0;
                        ovf_next   = 1'b0;
                        phase_next = P_LOAD;
                    end
                    else
                    begin
                        idx_next   = idx_reg + CW'(1);
                        phase_next = P_RD;
                    end
                end
            end
            default:
            begin
                phase_next = P_LOAD;
            end
        endcase
    end

    zss_magnitude u_mag
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (mag_start),
        .abs_diff (ad_reg),
        .nm1      (7'(nm1)),
        .dsum     (dsum_reg),
        .done     (mag_done),
        .mag      (mag)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= P_LOAD;
            count_reg   <= '0;
            sum_reg     <= '0;
            ovf_reg     <= 1'b0;
            idx_reg     <= '0;
            rd_vld_reg  <= 1'b0;
            acc_vld_reg <= 1'b0;
            ovalid_reg  <= 1'b0;
        end
        else
        begin
            phase_reg   <= phase_next;
            count_reg   <= count_next;
            sum_reg     <= sum_next;
            ovf_reg     <= ovf_next;
            idx_reg     <= idx_next;
            rd_vld_reg  <= rd_vld_next;
            acc_vld_reg <= acc_vld_next;
            ovalid_reg  <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dsum_reg <= dsum_next;
        stat_reg <= stat_next;
        neg_reg  <= neg_next;
        ad_reg   <= ad_next;
        out_reg  <= out_next;
    end

    assign m_axis_tvalid = ovalid_reg;
    assign m_axis_tdata  = out_reg.zscore;
    assign m_axis_tuser  = out_reg.status;
    assign m_axis_tlast  = out_reg.last_result;

    `ZS_ASSERT_ALWAYS(a_count_cap, count_reg <= CW'(MAX_SAMPLES), "sample count past capacity")
    `ZS_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "result dropped under stall")
    `ZS_ASSERT_ALWAYS(a_no_load_busy, !(s_axis_tready && phase_reg != P_LOAD), "input taken while busy")
endmodule
`default_nettype wire
